// File: rtl/biased_mf_sgd_update_top_macros.svh
// assertion macros for the biased matrix factorization sgd update block
// used by biased_mf_sgd_update_top, expects a clock named aclk and reset aresetn
`ifndef BIASED_MF_SGD_UPDATE_TOP_MACROS_SVH
`define BIASED_MF_SGD_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define BMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bmf_pkg.sv
// shared types, constants and helpers for the biased mf sgd update block
// no dependencies
`timescale 1ns / 1ps

package bmf_pkg;

    localparam int USER_BITS   = 16;
    localparam int ITEM_BITS   = 14;
    localparam int FACTOR_BITS = 4;
    localparam int FACTOR_COUNT = 16;
    localparam int UF_ADDR_BITS = USER_BITS + FACTOR_BITS;
    localparam int IF_ADDR_BITS = ITEM_BITS + FACTOR_BITS;

    localparam logic [18:0] ONE_Q16  = 19'd65536;
    localparam logic [18:0] FIVE_Q16 = 19'd327680;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 19;
    localparam int S_TDATA_BITS = 72;
    localparam int M_TDATA_BITS = 40;

    typedef enum logic [1:0] {
        OP_TRAIN    = 2'd0,
        OP_PREDICT  = 2'd1,
        OP_WR_USER  = 2'd2,
        OP_WR_ITEM  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BIAS_LR  = 3'd0,
        CFG_FACT_LR  = 3'd1,
        CFG_BIAS_REG = 3'd2,
        CFG_FACT_REG = 3'd3,
        CFG_MEAN     = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_DOT,
        ST_DRAIN,
        ST_PRED,
        ST_BIAS_MUL,
        ST_BIAS_STEP,
        ST_BIAS_WR,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_STEP,
        ST_UPD_WR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                   in_load;
        logic                   fac_write;
        logic                   bias_rd;
        logic                   acc_clr;
        logic                   dot_rd;
        logic                   pred_ld;
        logic                   bias_mul;
        logic                   bias_step;
        logic                   bias_wr;
        logic                   upd_rd;
        logic                   upd_mul;
        logic                   upd_step;
        logic                   upd_wr;
        logic                   out_load;
        logic                   out_zero;
        logic                   clr_wr;
        logic [FACTOR_BITS-1:0] k;
        logic [USER_BITS-1:0]   clr_addr;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic several;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sh007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -40'sh0080000000) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/bmf_ctrl.sv
// controller state machine: clearing pass, operation sequencing, result handshake
// depends on bmf_pkg
`timescale 1ns / 1ps

module bmf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  bmf_pkg::sts_t sts,
    output bmf_pkg::cmd_t cmd
);

    bmf_pkg::state_t                    state_reg, state_next;
    logic [bmf_pkg::FACTOR_BITS-1:0]    k_reg, k_next;
    logic [bmf_pkg::USER_BITS-1:0]      clr_reg, clr_next;
    logic                               drain_reg, drain_next;
    logic                               mvalid_reg, mvalid_next;
    logic                               k_last;

    assign k_last   = (k_reg == bmf_pkg::FACTOR_BITS'(bmf_pkg::FACTOR_COUNT - 1));
    assign m_tvalid = mvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bmf_pkg::ST_CLEAR;
            k_reg      <= '0;
            clr_reg    <= '0;
            drain_reg  <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            clr_reg    <= clr_next;
            drain_reg  <= drain_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        clr_next    = clr_reg;
        drain_next  = drain_reg;
        mvalid_next = mvalid_reg;
        cmd          = '0;
        cmd.k        = k_reg;
        cmd.clr_addr = clr_reg;
        s_tready     = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            bmf_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = bmf_pkg::ST_IDLE;
                end
            end
            bmf_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
                if (s_tvalid) begin
                    state_next = bmf_pkg::ST_DISPATCH;
                end
            end
            bmf_pkg::ST_DISPATCH: begin
                cmd.bias_rd = 1'b1;
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                drain_next  = 1'b0;
                if (sts.op == bmf_pkg::OP_WR_USER || sts.op == bmf_pkg::OP_WR_ITEM) begin
                    cmd.fac_write = 1'b1;
                    state_next    = bmf_pkg::ST_RESULT;
                end else if (sts.several) begin
                    state_next = bmf_pkg::ST_DOT;
                end else begin
                    state_next = bmf_pkg::ST_PRED;
                end
            end
            bmf_pkg::ST_DOT: begin
                cmd.dot_rd = 1'b1;
                k_next     = k_reg + 1'b1;
                if (k_last) begin
                    state_next = bmf_pkg::ST_DRAIN;
                end
            end
            bmf_pkg::ST_DRAIN: begin
                // products still in flight through the mac pipeline
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = bmf_pkg::ST_PRED;
                end
            end
            bmf_pkg::ST_PRED: begin
                cmd.pred_ld = 1'b1;
                k_next      = '0;
                state_next  = (sts.op == bmf_pkg::OP_TRAIN) ? bmf_pkg::ST_BIAS_MUL
                                                            : bmf_pkg::ST_RESULT;
            end
            bmf_pkg::ST_BIAS_MUL: begin
                cmd.bias_mul = 1'b1;
                state_next   = bmf_pkg::ST_BIAS_STEP;
            end
            bmf_pkg::ST_BIAS_STEP: begin
                cmd.bias_step = 1'b1;
                state_next    = bmf_pkg::ST_BIAS_WR;
            end
            bmf_pkg::ST_BIAS_WR: begin
                cmd.bias_wr = 1'b1;
                state_next  = bmf_pkg::ST_UPD_RD;
            end
            bmf_pkg::ST_UPD_RD: begin
                cmd.upd_rd = 1'b1;
                state_next = bmf_pkg::ST_UPD_MUL;
            end
            bmf_pkg::ST_UPD_MUL: begin
                cmd.upd_mul = 1'b1;
                state_next  = bmf_pkg::ST_UPD_STEP;
            end
            bmf_pkg::ST_UPD_STEP: begin
                cmd.upd_step = 1'b1;
                state_next   = bmf_pkg::ST_UPD_WR;
            end
            bmf_pkg::ST_UPD_WR: begin
                cmd.upd_wr = 1'b1;
                k_next     = k_reg + 1'b1;
                state_next = k_last ? bmf_pkg::ST_RESULT : bmf_pkg::ST_UPD_RD;
            end
            bmf_pkg::ST_RESULT: begin
                cmd.out_zero = (sts.op == bmf_pkg::OP_WR_USER ||
                                sts.op == bmf_pkg::OP_WR_ITEM);
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = bmf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bmf_datapath.sv
// datapath: config registers, bias and factor tables, mac, sgd update arithmetic
// depends on bmf_pkg
`timescale 1ns / 1ps

module bmf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [bmf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bmf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [1:0]                          s_tuser,
    input  logic [bmf_pkg::S_TDATA_BITS-1:0]    s_tdata,
    output logic [bmf_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  bmf_pkg::cmd_t                       cmd,
    output bmf_pkg::sts_t                       sts
);

    // configuration
    logic [15:0] blr_reg, flr_reg, breg_reg, freg_reg;
    logic [18:0] mean_reg;

    // latched input beat
    bmf_pkg::op_t                       op_reg;
    logic [bmf_pkg::USER_BITS-1:0]      u_reg;
    logic [bmf_pkg::ITEM_BITS-1:0]      i_reg;
    logic [2:0]                         rating_reg;
    logic                               several_reg;
    logic [bmf_pkg::FACTOR_BITS-1:0]    pos_reg;
    logic signed [31:0]                 fval_reg;

    // tables
    logic signed [31:0] ubias_mem [2**bmf_pkg::USER_BITS];
    logic signed [31:0] ibias_mem [2**bmf_pkg::ITEM_BITS];
    logic signed [31:0] ufact_mem [2**bmf_pkg::UF_ADDR_BITS];
    logic signed [31:0] ifact_mem [2**bmf_pkg::IF_ADDR_BITS];

    logic signed [31:0] ub_rd_reg, ib_rd_reg, p_rd_reg, q_rd_reg;

    // mac
    logic               dot_v1_reg, dot_v2_reg;
    logic signed [63:0] dot_prod_reg;
    logic signed [63:0] dot_prod_rnd;
    logic signed [55:0] acc_reg;

    // prediction
    logic signed [57:0] pred_sum;
    logic [18:0]        pred_clamp;
    logic signed [19:0] err_val;
    logic [18:0]        pred_reg;
    logic signed [19:0] err_reg;

    // bias update
    logic signed [48:0] ub_shr_reg, ib_shr_reg, ub_shr_t, ib_shr_t;
    logic signed [33:0] ub_diff, ib_diff;
    logic signed [50:0] ub_dl_reg, ib_dl_reg, ub_dl_t, ib_dl_t;
    logic signed [39:0] ub_sum, ib_sum;

    // factor update
    logic signed [51:0] eq_reg, ep_reg, eq_t, ep_t;
    logic signed [48:0] rp_reg, rq_reg, rp_t, rq_t;
    logic signed [36:0] gp, gq;
    logic signed [53:0] lp_reg, lq_reg, lp_t, lq_t;
    logic signed [39:0] p_sum, q_sum;

    logic [bmf_pkg::UF_ADDR_BITS-1:0] uf_addr;
    logic [bmf_pkg::IF_ADDR_BITS-1:0] if_addr;
    logic [bmf_pkg::FACTOR_BITS:0]    pos_ext;
    logic                             pos_ok;

    logic [bmf_pkg::M_TDATA_BITS-1:0] m_tdata_reg;

    assign sts.op      = op_reg;
    assign sts.several = several_reg;
    assign m_tdata     = m_tdata_reg;

    assign uf_addr = {u_reg, cmd.k};
    assign if_addr = {i_reg, cmd.k};
    assign pos_ext = {1'b0, pos_reg};
    assign pos_ok  = (pos_ext < (bmf_pkg::FACTOR_BITS + 1)'(bmf_pkg::FACTOR_COUNT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blr_reg  <= 16'd3277;
            flr_reg  <= 16'd3277;
            breg_reg <= 16'd655;
            freg_reg <= 16'd655;
            mean_reg <= 19'd229376;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bmf_pkg::CFG_BIAS_LR:  blr_reg  <= cfg_data[15:0];
                bmf_pkg::CFG_FACT_LR:  flr_reg  <= cfg_data[15:0];
                bmf_pkg::CFG_BIAS_REG: breg_reg <= cfg_data[15:0];
                bmf_pkg::CFG_FACT_REG: freg_reg <= cfg_data[15:0];
                bmf_pkg::CFG_MEAN:     mean_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg      <= bmf_pkg::op_t'(s_tuser);
            u_reg       <= s_tdata[15:0];
            i_reg       <= s_tdata[29:16];
            rating_reg  <= s_tdata[32:30];
            several_reg <= s_tdata[33];
            pos_reg     <= s_tdata[37:34];
            fval_reg    <= s_tdata[69:38];
        end
    end

    // bias tables
    always_ff @(posedge aclk) begin
        if (cmd.clr_wr) begin
            ubias_mem[cmd.clr_addr] <= '0;
            ibias_mem[cmd.clr_addr[bmf_pkg::ITEM_BITS-1:0]] <= '0;
        end else if (cmd.bias_wr) begin
            ubias_mem[u_reg] <= bmf_pkg::sat32(ub_sum);
            ibias_mem[i_reg] <= bmf_pkg::sat32(ib_sum);
        end
        if (cmd.bias_rd) begin
            ub_rd_reg <= ubias_mem[u_reg];
            ib_rd_reg <= ibias_mem[i_reg];
        end
    end

    // factor tables
    always_ff @(posedge aclk) begin
        if (cmd.fac_write && pos_ok && op_reg == bmf_pkg::OP_WR_USER) begin
            ufact_mem[{u_reg, pos_reg}] <= fval_reg;
        end else if (cmd.upd_wr) begin
            ufact_mem[uf_addr] <= bmf_pkg::sat32(p_sum);
        end
        if (cmd.fac_write && pos_ok && op_reg == bmf_pkg::OP_WR_ITEM) begin
            ifact_mem[{i_reg, pos_reg}] <= fval_reg;
        end else if (cmd.upd_wr) begin
            ifact_mem[if_addr] <= bmf_pkg::sat32(q_sum);
        end
        if (cmd.dot_rd || cmd.upd_rd) begin
            p_rd_reg <= ufact_mem[uf_addr];
            q_rd_reg <= ifact_mem[if_addr];
        end
    end

    // dot product: read, multiply, round and accumulate
    assign dot_prod_rnd = dot_prod_reg + 64'sd32768;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_v1_reg <= 1'b0;
            dot_v2_reg <= 1'b0;
        end else begin
            dot_v1_reg <= cmd.dot_rd;
            dot_v2_reg <= dot_v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (dot_v1_reg) begin
            dot_prod_reg <= p_rd_reg * q_rd_reg;
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (dot_v2_reg) begin
            acc_reg <= acc_reg + {{8{dot_prod_rnd[63]}}, dot_prod_rnd[63:16]};
        end
    end

    // prediction and error
    always_comb begin
        pred_sum = $signed({39'b0, mean_reg})
                 + {{26{ub_rd_reg[31]}}, ub_rd_reg}
                 + {{26{ib_rd_reg[31]}}, ib_rd_reg}
                 + (several_reg ? {{2{acc_reg[55]}}, acc_reg} : 58'sd0);
        if (pred_sum < $signed({39'b0, bmf_pkg::ONE_Q16})) begin
            pred_clamp = bmf_pkg::ONE_Q16;
        end else if (pred_sum > $signed({39'b0, bmf_pkg::FIVE_Q16})) begin
            pred_clamp = bmf_pkg::FIVE_Q16;
        end else begin
            pred_clamp = pred_sum[18:0];
        end
        if (op_reg == bmf_pkg::OP_TRAIN) begin
            err_val = $signed({1'b0, rating_reg, 16'b0}) - $signed({1'b0, pred_clamp});
        end else begin
            err_val = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pred_ld) begin
            pred_reg <= pred_clamp;
            err_reg  <= err_val;
        end
    end

    // bias update: b += round(lr * (e - round(reg * b)))
    assign ub_shr_t = ub_shr_reg + 49'sd32768;
    assign ib_shr_t = ib_shr_reg + 49'sd32768;
    assign ub_diff  = {{14{err_reg[19]}}, err_reg} - {ub_shr_t[48], ub_shr_t[48:16]};
    assign ib_diff  = {{14{err_reg[19]}}, err_reg} - {ib_shr_t[48], ib_shr_t[48:16]};
    assign ub_dl_t  = ub_dl_reg + 51'sd32768;
    assign ib_dl_t  = ib_dl_reg + 51'sd32768;
    assign ub_sum   = {{8{ub_rd_reg[31]}}, ub_rd_reg} + {{5{ub_dl_t[50]}}, ub_dl_t[50:16]};
    assign ib_sum   = {{8{ib_rd_reg[31]}}, ib_rd_reg} + {{5{ib_dl_t[50]}}, ib_dl_t[50:16]};

    always_ff @(posedge aclk) begin
        if (cmd.bias_mul) begin
            ub_shr_reg <= $signed({1'b0, breg_reg}) * ub_rd_reg;
            ib_shr_reg <= $signed({1'b0, breg_reg}) * ib_rd_reg;
        end
        if (cmd.bias_step) begin
            ub_dl_reg <= $signed({1'b0, blr_reg}) * ub_diff;
            ib_dl_reg <= $signed({1'b0, blr_reg}) * ib_diff;
        end
    end

    // factor update, both vectors from the old values
    assign eq_t  = eq_reg + 52'sd32768;
    assign ep_t  = ep_reg + 52'sd32768;
    assign rp_t  = rp_reg + 49'sd32768;
    assign rq_t  = rq_reg + 49'sd32768;
    assign gp    = {eq_t[51], eq_t[51:16]} - {{4{rp_t[48]}}, rp_t[48:16]};
    assign gq    = {ep_t[51], ep_t[51:16]} - {{4{rq_t[48]}}, rq_t[48:16]};
    assign lp_t  = lp_reg + 54'sd32768;
    assign lq_t  = lq_reg + 54'sd32768;
    assign p_sum = {{8{p_rd_reg[31]}}, p_rd_reg} + {{2{lp_t[53]}}, lp_t[53:16]};
    assign q_sum = {{8{q_rd_reg[31]}}, q_rd_reg} + {{2{lq_t[53]}}, lq_t[53:16]};

    always_ff @(posedge aclk) begin
        if (cmd.upd_mul) begin
            eq_reg <= err_reg * q_rd_reg;
            ep_reg <= err_reg * p_rd_reg;
            rp_reg <= $signed({1'b0, freg_reg}) * p_rd_reg;
            rq_reg <= $signed({1'b0, freg_reg}) * q_rd_reg;
        end
        if (cmd.upd_step) begin
            lp_reg <= $signed({1'b0, flr_reg}) * gp;
            lq_reg <= $signed({1'b0, flr_reg}) * gq;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_zero) begin
                m_tdata_reg <= '0;
            end else begin
                m_tdata_reg <= {1'b0, err_reg, pred_reg};
            end
        end
    end

endmodule

// File: rtl/biased_mf_sgd_update_top.sv
// A train runs the dot product over the factors (only when user_has_several is set), the
// prediction, the bias update and the factor update loop; a predict stops after the
// prediction; a factor write goes straight to the result. One item at a time: the next
// beat is taken in the cycle after the result loads; the factor loops through the single-port
// tables set the rate. The result register frees the input side while a result waits to be
// taken. Synchronous reset restores control and config registers; a clearing pass then zeroes the bias tables.
`timescale 1ns / 1ps
`include "biased_mf_sgd_update_top_macros.svh"

module biased_mf_sgd_update_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bmf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // user_index, item_index, rating, user_has_several, factor_position, factor_value
    input  logic [bmf_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // operation
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // prediction, error
    output logic [bmf_pkg::M_TDATA_BITS-1:0]    m_tdata
);

    bmf_pkg::cmd_t cmd;
    bmf_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    bmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bmf_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    `BMF_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second beat taken while busy")
    `BMF_ASSERT_NOW(a_pred_range, m_tvalid && m_tdata[18:0] != 19'd0,
        m_tdata[18:0] >= 19'd65536 && m_tdata[18:0] <= 19'd327680, "prediction out of range")
    `BMF_ASSERT_NOW(a_zero_err, m_tvalid && m_tdata[18:0] == 19'd0,
        m_tdata[38:19] == 20'd0, "write result with nonzero error")

endmodule
